[sv/urbc_pkg.sv]
// Package for the unlock relay and backoff controller.
// Shared widths, reset values, control types and the window threshold map.
// No dependencies.
package urbc_pkg;

  localparam int TimeBits   = 32;
  localparam int PeriodBits = 20;
  localparam int DeltaBits  = 16;
  localparam int RangeBits  = DeltaBits + 1;
  localparam int QlenBits   = 10;
  localparam int RandBits   = 32;
  localparam int CountBits  = 21;
  localparam int WinBits    = 10;
  localparam int StepBits   = 5;

  localparam logic [PeriodBits-1:0] PeriodReset = PeriodBits'(20000);
  localparam logic [DeltaBits-1:0]  DeltaReset  = DeltaBits'(100);
  localparam logic [StepBits-1:0]   LastStep    = StepBits'(RandBits - 1);

  // Register byte offsets are 0 and 4; bit 2 of paddr selects.
  localparam logic RegPeriod = 1'b0;
  localparam logic RegDelta  = 1'b1;

  localparam logic OpTick   = 1'b0;
  localparam logic OpUnlock = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_unlock;
    logic gap_ok;
  } dp_sts_t;

  function automatic logic [WinBits-1:0] window_for(input logic [QlenBits-1:0] qlen);
    logic [WinBits-1:0] w;
    if (qlen > QlenBits'(70))      w = WinBits'(1023);
    else if (qlen > QlenBits'(60)) w = WinBits'(511);
    else if (qlen > QlenBits'(50)) w = WinBits'(255);
    else if (qlen > QlenBits'(40)) w = WinBits'(63);
    else if (qlen > QlenBits'(20)) w = WinBits'(15);
    else if (qlen > QlenBits'(10)) w = WinBits'(7);
    else if (qlen > QlenBits'(5))  w = WinBits'(3);
    else                           w = WinBits'(1);
    return w;
  endfunction

endpackage

[sv/unlock_relay_backoff_controller.sv]
// A microsecond tick, or an unlock edge that falls within half a period of the
// previous one, is accepted and then evaluated. An unlock edge that is relayed
// is accepted, evaluated, then passes through 32 steps of the two bit-serial
// remainder units that reduce the random words modulo twice the backoff delta,
// and a finish state that forms the clamped reload. One result register sits on
// the output, so the next item can be taken while a result waits. Registers:
// period_us at byte 0, backoff_delta_us at byte 4.
module unlock_relay_backoff_controller (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 operation_i,
  input  logic [urbc_pkg::QlenBits-1:0]        queue_length_i,
  input  logic [urbc_pkg::RandBits-1:0]        jitter_random_i,
  input  logic [urbc_pkg::RandBits-1:0]        backoff_random_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 relay_pulse_o,
  output logic                                 window_valid_o,
  output logic [urbc_pkg::WinBits-1:0]         window_value_o,
  output logic [2*urbc_pkg::WinBits-1:0]       window_word_o,
  output logic                                 quiet_valid_o,
  output logic [urbc_pkg::RangeBits-1:0]       quiet_us_o,
  output logic [urbc_pkg::CountBits-1:0]       reload_us_o
);

  logic [urbc_pkg::PeriodBits-1:0] period_q;
  logic [urbc_pkg::DeltaBits-1:0]  delta_q;
  logic                            cfg_wr;
  urbc_pkg::dp_cmd_t               cmd;
  urbc_pkg::dp_sts_t               sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= urbc_pkg::PeriodReset;
      delta_q  <= urbc_pkg::DeltaReset;
    end else if (cfg_wr) begin
      if (paddr[2] == urbc_pkg::RegPeriod) period_q <= pwdata[urbc_pkg::PeriodBits-1:0];
      else                                 delta_q  <= pwdata[urbc_pkg::DeltaBits-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == urbc_pkg::RegDelta) prdata = 32'(delta_q);
    else                                prdata = 32'(period_q);
  end

  urbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  urbc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .period_i         (period_q),
    .delta_i          (delta_q),
    .operation_i      (operation_i),
    .queue_length_i   (queue_length_i),
    .jitter_random_i  (jitter_random_i),
    .backoff_random_i (backoff_random_i),
    .relay_pulse_o    (relay_pulse_o),
    .window_valid_o   (window_valid_o),
    .window_value_o   (window_value_o),
    .window_word_o    (window_word_o),
    .quiet_valid_o    (quiet_valid_o),
    .quiet_us_o       (quiet_us_o),
    .reload_us_o      (reload_us_o)
  );

  // a started backoff always comes with a relayed pulse and an applied window
  a_quiet_relay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && quiet_valid_o |-> relay_pulse_o && window_valid_o)
    else $error("quiet backoff without relay pulse");

  a_window_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !window_valid_o |-> window_value_o == '0 && !relay_pulse_o)
    else $error("window value without window valid");

  a_quiet_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && quiet_valid_o |->
      (delta_q == '0 && quiet_us_o == '0) ||
      (delta_q != '0 && quiet_us_o < {delta_q, 1'b0}))
    else $error("quiet duration outside twice delta");

  // one item at a time: after a transaction is taken the input stalls
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

endmodule

[sv/urbc_ctrl.sv]
// Sequencing FSM for the unlock relay and backoff controller.
// Drives datapath commands and the output valid flag; uses urbc_pkg.
module urbc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  urbc_pkg::dp_sts_t sts_i,
  output urbc_pkg::dp_cmd_t cmd_o
);

  urbc_pkg::ctrl_state_e state_q, state_d;
  logic [urbc_pkg::StepBits-1:0] step_q, step_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= urbc_pkg::ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      urbc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = urbc_pkg::ST_EVAL;
        end
      end
      urbc_pkg::ST_EVAL: begin
        if (sts_i.is_unlock && sts_i.gap_ok) begin
          cmd_o.div_start = 1'b1;
          step_d          = '0;
          state_d         = urbc_pkg::ST_DIV;
        end else if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = urbc_pkg::ST_IDLE;
        end
      end
      urbc_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == urbc_pkg::LastStep) state_d = urbc_pkg::ST_DONE;
      end
      urbc_pkg::ST_DONE: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = urbc_pkg::ST_IDLE;
        end
      end
      default: state_d = urbc_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.commit ? 1'b1 : (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

endmodule

[sv/urbc_dp.sv]
// Datapath for the unlock relay and backoff controller: time state, countdown,
// two bit-serial remainder units and the result register. Uses urbc_pkg.
module urbc_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  urbc_pkg::dp_cmd_t                    cmd_i,
  output urbc_pkg::dp_sts_t                    sts_o,
  input  logic [urbc_pkg::PeriodBits-1:0]      period_i,
  input  logic [urbc_pkg::DeltaBits-1:0]       delta_i,
  input  logic                                 operation_i,
  input  logic [urbc_pkg::QlenBits-1:0]        queue_length_i,
  input  logic [urbc_pkg::RandBits-1:0]        jitter_random_i,
  input  logic [urbc_pkg::RandBits-1:0]        backoff_random_i,
  output logic                                 relay_pulse_o,
  output logic                                 window_valid_o,
  output logic [urbc_pkg::WinBits-1:0]         window_value_o,
  output logic [2*urbc_pkg::WinBits-1:0]       window_word_o,
  output logic                                 quiet_valid_o,
  output logic [urbc_pkg::RangeBits-1:0]       quiet_us_o,
  output logic [urbc_pkg::CountBits-1:0]       reload_us_o
);

  localparam int TB = urbc_pkg::TimeBits;
  localparam int RB = urbc_pkg::RangeBits;
  localparam int CB = urbc_pkg::CountBits;

  // latched item
  logic                          op_q;
  logic [urbc_pkg::QlenBits-1:0] qlen_q;
  logic [urbc_pkg::RandBits-1:0] jdiv_q, bdiv_q;
  logic [RB-1:0]                 jrem_q, brem_q, jrem_d, brem_d;
  logic                          prev_le_q;

  // block state
  logic [TB-1:0] clock_q, last_q, prior_q;
  logic [CB-1:0] count_q;

  // result register
  logic                          relay_q, wvalid_q, qvalid_q;
  logic [urbc_pkg::WinBits-1:0]  wvalue_q;
  logic [RB-1:0]                 quiet_q;
  logic [CB-1:0]                 reload_q;

  logic [RB-1:0]                 range;
  logic [TB-1:0]                 gap;
  logic [urbc_pkg::PeriodBits:0] period_p1;
  logic [urbc_pkg::PeriodBits-1:0] half;
  logic                          gap_ok;
  logic [urbc_pkg::WinBits-1:0]  win;
  logic [RB-1:0]                 jit, bko;
  logic signed [CB+1:0]          next_s;
  logic [CB-1:0]                 next_u;
  logic                          expire;
  logic [RB:0]                   jtrial, btrial;

  assign range     = {delta_i, 1'b0};
  assign gap       = clock_q - last_q;
  assign period_p1 = {1'b0, period_i} + 1'b1;
  assign half      = period_p1[urbc_pkg::PeriodBits:1];
  assign gap_ok    = gap >= TB'(half);
  assign win       = urbc_pkg::window_for(qlen_q);
  assign expire    = count_q <= CB'(1);

  assign sts_o.is_unlock = (op_q == urbc_pkg::OpUnlock);
  assign sts_o.gap_ok    = gap_ok;

  // restoring remainder step, one dividend bit per cycle
  assign jtrial = {jrem_q, jdiv_q[urbc_pkg::RandBits-1]};
  assign btrial = {brem_q, bdiv_q[urbc_pkg::RandBits-1]};
  assign jrem_d = (jtrial >= {1'b0, range}) ? RB'(jtrial - {1'b0, range}) : jtrial[RB-1:0];
  assign brem_d = (btrial >= {1'b0, range}) ? RB'(btrial - {1'b0, range}) : btrial[RB-1:0];

  // a zero range leaves garbage in the remainders: force zero
  assign jit = (range == '0) ? '0 : jrem_q;
  assign bko = (range == '0) ? '0 : brem_q;

  always_comb begin
    if (prev_le_q) next_s = (CB+2)'(period_i) + (CB+2)'(jit);
    else           next_s = (CB+2)'(period_i) - (CB+2)'(jit);
    next_s = next_s - (CB+2)'(bko);
    next_u = next_s[CB+1] ? '0 : next_s[CB-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= operation_i;
      qlen_q <= queue_length_i;
      jdiv_q <= jitter_random_i;
      bdiv_q <= backoff_random_i;
    end else if (cmd_i.div_step) begin
      jdiv_q <= {jdiv_q[urbc_pkg::RandBits-2:0], 1'b0};
      bdiv_q <= {bdiv_q[urbc_pkg::RandBits-2:0], 1'b0};
    end
    if (cmd_i.div_start) begin
      jrem_q    <= '0;
      brem_q    <= '0;
      prev_le_q <= (last_q - prior_q) <= TB'(period_i);
    end else if (cmd_i.div_step) begin
      jrem_q <= jrem_d;
      brem_q <= brem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q <= '0;
      last_q  <= '0;
      prior_q <= '0;
      count_q <= CB'(urbc_pkg::PeriodReset);
    end else if (cmd_i.commit) begin
      if (op_q == urbc_pkg::OpTick) begin
        clock_q <= clock_q + 1'b1;
        count_q <= expire ? CB'(period_i) : count_q - 1'b1;
      end else if (gap_ok) begin
        prior_q <= last_q;
        last_q  <= clock_q;
        count_q <= next_u;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      relay_q  <= 1'b0;
      wvalid_q <= 1'b0;
      wvalue_q <= '0;
      qvalid_q <= 1'b0;
      quiet_q  <= '0;
      reload_q <= '0;
      if (op_q == urbc_pkg::OpTick) begin
        if (expire) begin
          relay_q  <= 1'b1;
          wvalid_q <= 1'b1;
          wvalue_q <= win;
          reload_q <= CB'(period_i);
        end
      end else begin
        wvalid_q <= 1'b1;
        wvalue_q <= win;
        if (gap_ok) begin
          relay_q  <= 1'b1;
          qvalid_q <= 1'b1;
          quiet_q  <= bko;
          reload_q <= next_u;
        end
      end
    end
  end

  assign relay_pulse_o  = relay_q;
  assign window_valid_o = wvalid_q;
  assign window_value_o = wvalue_q;
  assign window_word_o  = {wvalue_q, wvalue_q};
  assign quiet_valid_o  = qvalid_q;
  assign quiet_us_o     = quiet_q;
  assign reload_us_o    = reload_q;

endmodule

[verif/tb_unlock_relay_backoff_controller.sv]
// Testbench for unlock_relay_backoff_controller: directed rows, then random phases.
// Each result is checked against the row's fixed expectation or a cycle-free predictor.
// Depends on urbc_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb_unlock_relay_backoff_controller;
  import urbc_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int HoldCycles = 400;
  localparam int IdlePct    = 22;

  typedef struct packed {
    logic                   relay;
    logic                   win_valid;
    logic [WinBits-1:0]     win_value;
    logic [2*WinBits-1:0]   win_word;
    logic                   quiet_valid;
    logic [RangeBits-1:0]   quiet;
    logic [CountBits-1:0]   reload;
  } relay_result_t;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_PERIOD,
    ROW_DELTA
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic                  op;
    logic [QlenBits-1:0]   qlen;
    logic [RandBits-1:0]   jrand;
    logic [RandBits-1:0]   brand;
    logic [31:0]           value;
    logic                  known;
    relay_result_t         want;
  } stim_row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [2:0]               paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     operation_i;
  logic [QlenBits-1:0]      queue_length_i;
  logic [RandBits-1:0]      jitter_random_i;
  logic [RandBits-1:0]      backoff_random_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic                     relay_pulse_o;
  logic                     window_valid_o;
  logic [WinBits-1:0]       window_value_o;
  logic [2*WinBits-1:0]     window_word_o;
  logic                     quiet_valid_o;
  logic [RangeBits-1:0]     quiet_us_o;
  logic [CountBits-1:0]     reload_us_o;

  // Predictor state and register copies
  logic [TimeBits-1:0]      now_us;
  logic [TimeBits-1:0]      last_us;
  logic [TimeBits-1:0]      prior_us;
  logic [CountBits-1:0]     countdown;
  logic [PeriodBits-1:0]    cfg_period;
  logic [DeltaBits-1:0]     cfg_delta;

  relay_result_t            expected_results[$];
  stim_row_t                stim_rows[$];
  int                       error_count;
  int                       cycle_count;
  int                       hold_asks;
  int                       hold_seen;
  int                       hold_left;
  bit                       calm;

  unlock_relay_backoff_controller u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .queue_length_i   (queue_length_i),
    .jitter_random_i  (jitter_random_i),
    .backoff_random_i (backoff_random_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .relay_pulse_o    (relay_pulse_o),
    .window_valid_o   (window_valid_o),
    .window_value_o   (window_value_o),
    .window_word_o    (window_word_o),
    .quiet_valid_o    (quiet_valid_o),
    .quiet_us_o       (quiet_us_o),
    .reload_us_o      (reload_us_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Thresholds ascending; the last one passed picks the window.
  function automatic logic [WinBits-1:0] contention_window(logic [QlenBits-1:0] q);
    int unsigned limits[7];
    int unsigned sizes[7];
    logic [WinBits-1:0] w;
    limits = '{5, 10, 20, 40, 50, 60, 70};
    sizes  = '{3, 7, 15, 63, 255, 511, 1023};
    w = WinBits'(1);
    for (int i = 0; i < 7; i++) begin
      if (q > limits[i]) w = WinBits'(sizes[i]);
    end
    return w;
  endfunction

  function automatic relay_result_t predict_relay(logic op, logic [QlenBits-1:0] q,
                                                  logic [RandBits-1:0] jr,
                                                  logic [RandBits-1:0] br);
    relay_result_t      r;
    logic [WinBits-1:0] w;
    logic [TimeBits-1:0] gap;
    logic [TimeBits-1:0] prev_gap;
    logic [PeriodBits:0] half;
    logic [RangeBits-1:0] span;
    logic [RangeBits-1:0] jit;
    logic [RangeBits-1:0] bko;
    longint             next;
    bit                 fired;
    r = '0;
    fired = 1'b0;
    w = contention_window(q);
    if (op == OpTick) begin
      now_us = now_us + 1'b1;
      if (countdown <= 1) begin
        fired = 1'b1;
        countdown = CountBits'(cfg_period);
        r.relay = 1'b1;
        r.reload = countdown;
      end else begin
        countdown = countdown - 1'b1;
      end
    end else begin
      gap = now_us - last_us;
      half = ({1'b0, cfg_period} + 1'b1) >> 1;
      if (gap >= half) begin
        span = {cfg_delta, 1'b0};
        jit = (span == 0) ? '0 : RangeBits'(jr % span);
        bko = (span == 0) ? '0 : RangeBits'(br % span);
        prev_gap = last_us - prior_us;
        if (prev_gap <= cfg_period) next = longint'(cfg_period) + longint'(jit);
        else next = longint'(cfg_period) - longint'(jit);
        next = next - longint'(bko);
        if (next < 0) next = 0;
        prior_us = last_us;
        last_us = now_us;
        countdown = next[CountBits-1:0];
        r.relay = 1'b1;
        r.quiet_valid = 1'b1;
        r.quiet = bko;
        r.reload = countdown;
      end
    end
    if (op == OpUnlock || fired) begin
      r.win_valid = 1'b1;
      r.win_value = w;
      r.win_word = {w, w};
    end
    return r;
  endfunction

  function automatic stim_row_t item_row(logic op, logic [QlenBits-1:0] q,
                                         logic [RandBits-1:0] jr, logic [RandBits-1:0] br);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.op = op;
    r.qlen = q;
    r.jrand = jr;
    r.brand = br;
    return r;
  endfunction

  // Unlock too close to the previous one: only the window comes out.
  function automatic stim_row_t window_row(logic [QlenBits-1:0] q, int unsigned w,
                                           logic [RandBits-1:0] rnd);
    stim_row_t r;
    r = item_row(OpUnlock, q, rnd, ~rnd);
    r.known = 1'b1;
    r.want.win_valid = 1'b1;
    r.want.win_value = WinBits'(w);
    r.want.win_word = {WinBits'(w), WinBits'(w)};
    return r;
  endfunction

  function automatic stim_row_t reg_row(row_kind_e kind, logic [31:0] value);
    stim_row_t r;
    r = '0;
    r.kind = kind;
    r.value = value;
    return r;
  endfunction

  task automatic send_item(logic op, logic [QlenBits-1:0] q, logic [RandBits-1:0] jr,
                           logic [RandBits-1:0] br, logic known, relay_result_t want);
    relay_result_t guess;
    if (!calm) begin
      while ($urandom_range(0, 99) < IdlePct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i       <= 1'b1;
    operation_i      <= op;
    queue_length_i   <= q;
    jitter_random_i  <= jr;
    backoff_random_i <= br;
    do @(posedge clk_i); while (in_stall_o);
    guess = predict_relay(op, q, jr, br);
    expected_results.push_back(known ? want : guess);
  endtask

  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(logic idx, logic [31:0] value);
    logic [31:0] held;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == RegPeriod) cfg_period = value[PeriodBits-1:0];
    else cfg_delta = value[DeltaBits-1:0];
    held = (idx == RegPeriod) ? 32'(cfg_period) : 32'(cfg_delta);
    // read back
    @(posedge clk_i);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata !== held)
      report_error($sformatf("register %0d read 0x%0h, wrote 0x%0h", idx, prdata, held));
  endtask

  always @(posedge clk_i) begin : collect_results
    relay_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_error("result with no transaction pending");
      end else begin
        want = expected_results.pop_front();
        if (relay_pulse_o !== want.relay)
          report_error($sformatf("relay_pulse %0h want %0h", relay_pulse_o, want.relay));
        if (window_valid_o !== want.win_valid)
          report_error($sformatf("window_valid %0h want %0h", window_valid_o,
                                 want.win_valid));
        if (window_value_o !== want.win_value)
          report_error($sformatf("window_value %0d want %0d", window_value_o,
                                 want.win_value));
        if (window_word_o !== want.win_word)
          report_error($sformatf("window_word 0x%0h want 0x%0h", window_word_o,
                                 want.win_word));
        if (quiet_valid_o !== want.quiet_valid)
          report_error($sformatf("quiet_valid %0h want %0h", quiet_valid_o,
                                 want.quiet_valid));
        if (quiet_us_o !== want.quiet)
          report_error($sformatf("quiet_us %0d want %0d", quiet_us_o, want.quiet));
        if (reload_us_o !== want.reload)
          report_error($sformatf("reload_us %0d want %0d", reload_us_o, want.reload));
      end
    end
    // long hold-off so the block backs up into its input
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) hold_left--;
    out_stall_i <= (hold_left > 0) || (!calm && ($urandom_range(0, 99) < IdlePct));
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_unlock_relay_backoff_controller failed");
      $finish;
    end
  end

  initial begin
    stim_row_t     r;
    relay_result_t none;
    int unsigned   per;
    int unsigned   del;
    logic          op;
    logic [QlenBits-1:0] q;

    none        = '0;
    error_count = 0;
    cycle_count = 0;
    hold_asks   = 0;
    hold_seen   = 0;
    hold_left   = 0;
    calm        = 1'b0;
    now_us      = '0;
    last_us     = '0;
    prior_us    = '0;
    countdown   = CountBits'(PeriodReset);
    cfg_period  = PeriodReset;
    cfg_delta   = DeltaReset;

    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_valid_i       <= 1'b0;
    operation_i      <= OpTick;
    queue_length_i   <= '0;
    jitter_random_i  <= '0;
    backoff_random_i <= '0;
    out_stall_i      <= 1'b0;

    // After reset a tick only moves the countdown; close unlocks sweep thresholds.
    r = item_row(OpTick, '0, '0, '0);
    r.known = 1'b1;
    stim_rows.push_back(r);
    stim_rows.push_back(window_row(10'd1023, 1023, 32'hFFFF_FFFF));
    stim_rows.push_back(window_row(10'd0, 1, 32'h0));
    stim_rows.push_back(window_row(10'd5, 1, 32'hFFFF_FFFF));
    stim_rows.push_back(window_row(10'd6, 3, 32'h0));
    stim_rows.push_back(window_row(10'd10, 3, 32'hA5A5_5A5A));
    stim_rows.push_back(window_row(10'd11, 7, 32'h0));
    stim_rows.push_back(window_row(10'd20, 7, 32'hFFFF_FFFF));
    stim_rows.push_back(window_row(10'd21, 15, 32'h0));
    stim_rows.push_back(window_row(10'd40, 15, 32'h1234_5678));
    stim_rows.push_back(window_row(10'd41, 63, 32'h0));
    stim_rows.push_back(window_row(10'd50, 63, 32'hFFFF_FFFF));
    stim_rows.push_back(window_row(10'd51, 255, 32'h0));
    stim_rows.push_back(window_row(10'd60, 255, 32'h8000_0001));
    stim_rows.push_back(window_row(10'd61, 511, 32'h0));
    stim_rows.push_back(window_row(10'd70, 511, 32'hFFFF_FFFF));
    stim_rows.push_back(window_row(10'd71, 1023, 32'h0));
    // shortest period: accepted unlock, then clamp at zero, then back-to-back expiry
    stim_rows.push_back(reg_row(ROW_PERIOD, 32'd1));
    stim_rows.push_back(item_row(OpUnlock, 10'd30, 32'hFFFF_FFFF, 32'h0));
    stim_rows.push_back(reg_row(ROW_DELTA, 32'hFFFF));
    stim_rows.push_back(item_row(OpTick, 10'd7, 32'h0, 32'h0));
    stim_rows.push_back(item_row(OpUnlock, 10'd3, 32'h0, 32'hFFFF_FFFF));
    stim_rows.push_back(item_row(OpTick, 10'd71, 32'h0, 32'h0));
    stim_rows.push_back(item_row(OpTick, 10'd0, 32'h0, 32'h0));
    // zero delta: no jitter, no backoff
    stim_rows.push_back(reg_row(ROW_DELTA, 32'd0));
    stim_rows.push_back(item_row(OpTick, 10'd12, 32'h0, 32'h0));
    stim_rows.push_back(item_row(OpUnlock, 10'd45, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // longest period, smallest nonzero delta
    stim_rows.push_back(reg_row(ROW_PERIOD, 32'hF_FFFF));
    stim_rows.push_back(reg_row(ROW_DELTA, 32'd1));
    stim_rows.push_back(item_row(OpTick, 10'd55, 32'h0, 32'h0));
    stim_rows.push_back(item_row(OpUnlock, 10'd65, 32'h7FFF_FFFF, 32'h8000_0000));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_rows[i]) begin
      case (stim_rows[i].kind)
        ROW_ITEM: begin
          send_item(stim_rows[i].op, stim_rows[i].qlen, stim_rows[i].jrand,
                    stim_rows[i].brand, stim_rows[i].known, stim_rows[i].want);
        end
        ROW_PERIOD: begin
          settle_block();
          write_register(RegPeriod, stim_rows[i].value);
        end
        default: begin
          settle_block();
          write_register(RegDelta, stim_rows[i].value);
        end
      endcase
    end

    // Random phases: mostly ticks, unlocks often enough to get past half a period.
    for (int p = 0; p < 7; p++) begin
      settle_block();
      case (p)
        2: begin
          per = $urandom_range(1, 40);
          del = 32'hFFFF;
        end
        3: begin
          per = $urandom_range(100, 400);
          del = $urandom_range(1, 200);
        end
        4: begin
          per = $urandom_range(2, 60);
          del = 1;
        end
        default: begin
          per = $urandom_range(1, 150);
          del = $urandom_range(1, 100);
        end
      endcase
      write_register(RegPeriod, per);
      write_register(RegDelta, del);
      calm = (p == 1);
      if (p == 0 || p == 5) hold_asks++;
      repeat (185) begin
        op = ($urandom_range(0, 5) == 0) ? OpUnlock : OpTick;
        q = $urandom_range(0, 1) ? QlenBits'($urandom_range(0, 80))
                                 : QlenBits'($urandom_range(0, 1023));
        send_item(op, q, $urandom, $urandom, 1'b0, none);
      end
    end

    settle_block();
    repeat (40) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb_unlock_relay_backoff_controller passed");
    end else begin
      $display("tb_unlock_relay_backoff_controller failed");
    end
    $finish;
  end

endmodule

[files.f]
sv/urbc_pkg.sv
sv/urbc_ctrl.sv
sv/urbc_dp.sv
sv/unlock_relay_backoff_controller.sv
verif/tb_unlock_relay_backoff_controller.sv
